// ----- design/vprm_pkg.sv -----
// Shared constants, types and controller encoding for the page residency manager.
`default_nettype none

package vprm_pkg;

	localparam int VIRTUAL_PAGES  = 64;
	localparam int PHYSICAL_SLOTS = 8;

	localparam int PAGE_W  = 6;
	localparam int SLOT_W  = (PHYSICAL_SLOTS > 1) ? $clog2(PHYSICAL_SLOTS) : 1;
	localparam int LOADS_W = 4;
	localparam int ROUND_W = 32;
	localparam int LCNT_W  = $clog2(PHYSICAL_SLOTS + 1);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} vprm_state_t;

	// controller -> datapath
	typedef struct packed {
		logic set_bit;   // record the incoming request in the bitmap
		logic start;     // rewind page pointer, clear round load count
		logic adv;       // step to the next page
		logic load;      // claim slot, update owners, write load word
		logic done;      // write done word, clear bitmap, bump round count
	} vprm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_load;   // current page requested and not resident
		logic slot_found;  // free or evictable slot exists
		logic page_last;   // pointer at the highest page
		logic out_free;    // output register can take a word this cycle
	} vprm_sts_t;

endpackage

`default_nettype wire

// ----- design/vprm_ctrl.sv -----
// Controller: sequences request collection, the residency scan and the done word.
`default_nettype none

module vprm_ctrl import vprm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	input  wire logic      batch_last,
	output logic           req_stall,
	input  wire vprm_sts_t sts,
	output vprm_cmd_t      cmd
);

	vprm_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && batch_last) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!sts.need_load) begin
					if (sts.page_last) begin
						state_nxt = ST_DONE;
					end
				end else if (!sts.slot_found) begin
					state_nxt = ST_DONE;
				end else if (sts.out_free && sts.page_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall   = 1'b0;
				cmd.set_bit = req_valid;
				cmd.start   = req_valid && batch_last;
			end
			ST_SCAN: begin
				if (!sts.need_load) begin
					cmd.adv = 1'b1;
				end else if (sts.slot_found && sts.out_free) begin
					cmd.load = 1'b1;
					cmd.adv  = 1'b1;
				end
			end
			ST_DONE: begin
				cmd.done = sts.out_free;
			end
			default: begin
				cmd       = '0;
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/vprm_dpath.sv -----
// Datapath: request bitmap, slot owners, slot search and the output word register.
`default_nettype none

module vprm_dpath import vprm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [PAGE_W-1:0]   requested_page,
	input  wire vprm_cmd_t           cmd,
	output vprm_sts_t                sts,
	input  wire logic                cmd_stall,
	output logic                     cmd_valid,
	output logic                     item_kind,
	output logic [PAGE_W-1:0]        load_page,
	output logic [SLOT_W-1:0]        load_slot,
	output logic                     evict_valid,
	output logic [PAGE_W-1:0]        evict_page,
	output logic [LOADS_W-1:0]       round_loads,
	output logic [ROUND_W-1:0]       total_rounds,
	output logic                     last_of_run
);

	logic [VIRTUAL_PAGES-1:0]  req_map_q;
	logic [PHYSICAL_SLOTS-1:0] own_vld_q;
	logic [PAGE_W-1:0]         own_page_q [PHYSICAL_SLOTS];
	logic [PAGE_W-1:0]         page_q;
	logic [LCNT_W-1:0]         loads_q;
	logic [ROUND_W-1:0]        rounds_q;
	logic                      out_vld_q;

	logic [PHYSICAL_SLOTS-1:0] hit_vec, victim_vec;
	logic                      resident, any_free, any_victim;
	logic [SLOT_W-1:0]         free_idx, victim_idx, slot_sel;
	logic                      out_free;

	// residency is implied by slot ownership: a page is resident iff a valid slot owns it
	always_comb begin
		for (int i = 0; i < PHYSICAL_SLOTS; i++) begin
			hit_vec[i]    = own_vld_q[i] && (own_page_q[i] == page_q);
			victim_vec[i] = own_vld_q[i] && !req_map_q[own_page_q[i]];
		end
	end

	assign resident   = |hit_vec;
	assign any_free   = ~&own_vld_q;
	assign any_victim = |victim_vec;

	// lowest-index priority encoders
	always_comb begin
		free_idx   = '0;
		victim_idx = '0;
		for (int i = PHYSICAL_SLOTS - 1; i >= 0; i--) begin
			if (!own_vld_q[i]) begin
				free_idx = SLOT_W'(i);
			end
			if (victim_vec[i]) begin
				victim_idx = SLOT_W'(i);
			end
		end
	end

	assign slot_sel = any_free ? free_idx : victim_idx;
	assign out_free = !out_vld_q || !cmd_stall;

	assign sts.need_load  = req_map_q[page_q] && !resident;
	assign sts.slot_found = any_free || any_victim;
	assign sts.page_last  = (page_q == PAGE_W'(VIRTUAL_PAGES - 1));
	assign sts.out_free   = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_map_q <= '0;
			own_vld_q <= '0;
			page_q    <= '0;
			loads_q   <= '0;
			rounds_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.done) begin
				req_map_q <= '0;
			end else if (cmd.set_bit && (int'(requested_page) < VIRTUAL_PAGES)) begin
				req_map_q[requested_page] <= 1'b1;
			end
			if (cmd.start) begin
				page_q  <= '0;
				loads_q <= '0;
			end else begin
				if (cmd.adv) begin
					page_q <= page_q + 1'b1;
				end
				if (cmd.load) begin
					loads_q <= loads_q + 1'b1;
				end
			end
			if (cmd.load) begin
				own_vld_q[slot_sel] <= 1'b1;
			end
			if (cmd.done) begin
				rounds_q <= rounds_q + 1'b1;
			end
			if (cmd.load || cmd.done) begin
				out_vld_q <= 1'b1;
			end else if (!cmd_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			own_page_q[slot_sel] <= page_q;
		end
	end

	// output word register, payload only
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_kind    <= KIND_LOAD;
			load_page    <= page_q;
			load_slot    <= slot_sel;
			evict_valid  <= own_vld_q[slot_sel];
			evict_page   <= own_vld_q[slot_sel] ? own_page_q[slot_sel] : '0;
			round_loads  <= '0;
			total_rounds <= '0;
			last_of_run  <= 1'b0;
		end else if (cmd.done) begin
			item_kind    <= KIND_DONE;
			load_page    <= '0;
			load_slot    <= '0;
			evict_valid  <= 1'b0;
			evict_page   <= '0;
			round_loads  <= LOADS_W'(loads_q);
			total_rounds <= rounds_q + 1'b1;
			last_of_run  <= 1'b1;
		end
	end

	assign cmd_valid = out_vld_q;

endmodule

`default_nettype wire

// ----- design/virtual_page_residency_manager.sv -----
// Top level of the virtual page residency manager: controller plus datapath.
//
// Each accepted request word marks its page in a 64-entry requested bitmap;
// requests are taken back to back while the block is collecting.
// A request with batch_last starts the residency pass, during which req_stall is
// high. The pass visits pages 0..63 in order, one page per cycle unless a load
// word has to wait for room in the output register while the output side
// stalls. Each requested, non-resident page takes the lowest free slot, or else
// the lowest slot whose page is not requested this round (that page is evicted),
// and produces a load word. If no slot qualifies the pass ends early. A done word
// (last_of_run high) carrying the round's load count and the running round count
// closes the round and clears the bitmap. Residency is derived from the eight
// slot owner registers by compare, so there is no separate page table and no
// clearing pass after reset. Results leave through a single output register, so
// collection of the next batch can begin while the done word is still waiting.
`default_nettype none

module virtual_page_residency_manager import vprm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic [PAGE_W-1:0]   requested_page,
	input  wire logic                batch_last,
	// result channel
	output logic                     cmd_valid,
	input  wire logic                cmd_stall,
	output logic                     item_kind,
	output logic [PAGE_W-1:0]        load_page,
	output logic [SLOT_W-1:0]        load_slot,
	output logic                     evict_valid,
	output logic [PAGE_W-1:0]        evict_page,
	output logic [LOADS_W-1:0]       round_loads,
	output logic [ROUND_W-1:0]       total_rounds,
	output logic                     last_of_run
);

	vprm_cmd_t cmd;
	vprm_sts_t sts;

	vprm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.batch_last (batch_last),
		.req_stall  (req_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	vprm_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.requested_page (requested_page),
		.cmd            (cmd),
		.sts            (sts),
		.cmd_stall      (cmd_stall),
		.cmd_valid      (cmd_valid),
		.item_kind      (item_kind),
		.load_page      (load_page),
		.load_slot      (load_slot),
		.evict_valid    (evict_valid),
		.evict_page     (evict_page),
		.round_loads    (round_loads),
		.total_rounds   (total_rounds),
		.last_of_run    (last_of_run)
	);

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the virtual page residency manager.

module tb_top;
	import vprm_pkg::*;

	// Quiet cycles allowed before the run is called hung. The worst honest case is
	// a full 64-page pass with no loads, plus a long result stall and a sender gap.
	localparam int QUIET_LIMIT = 1000;
	// Random part stops once this many request words are queued in total.
	localparam int REQUEST_TARGET = 310;
	// Cycles to linger after the last expected word: one full pass and then some.
	localparam int DRAIN_CYCLES = 100;
	localparam int REPORT_MAX = 10;

	// One request word as the sender holds it.
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              is_last;
	} page_req_t;

	// One result word, field for field as it leaves the block.
	typedef struct packed {
		logic               kind;
		logic [PAGE_W-1:0]  load_page;
		logic [SLOT_W-1:0]  load_slot;
		logic               evict_valid;
		logic [PAGE_W-1:0]  evict_page;
		logic [LOADS_W-1:0] round_loads;
		logic [ROUND_W-1:0] total_rounds;
		logic               last_of_run;
	} cmd_word_t;

	// How the result side pushes back; the mode is switched at random.
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_ALTERNATE,
		STALL_LONG
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [PAGE_W-1:0]  requested_page = '0;
	logic               batch_last = 1'b0;
	logic               cmd_valid;
	logic               cmd_stall = 1'b0;
	logic               item_kind;
	logic [PAGE_W-1:0]  load_page;
	logic [SLOT_W-1:0]  load_slot;
	logic               evict_valid;
	logic [PAGE_W-1:0]  evict_page;
	logic [LOADS_W-1:0] round_loads;
	logic [ROUND_W-1:0] total_rounds;
	logic               last_of_run;

	virtual_page_residency_manager dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.requested_page (requested_page),
		.batch_last     (batch_last),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.item_kind      (item_kind),
		.load_page      (load_page),
		.load_slot      (load_slot),
		.evict_valid    (evict_valid),
		.evict_page     (evict_page),
		.round_loads    (round_loads),
		.total_rounds   (total_rounds),
		.last_of_run    (last_of_run)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Residency predictor: its own copy of the bitmap, page table and slot
	// owners. page_slot holds slot+1 for a resident page, zero otherwise.
	// ------------------------------------------------------------------
	logic                page_wanted [VIRTUAL_PAGES]  = '{default: 1'b0};
	logic [SLOT_W:0]     page_slot   [VIRTUAL_PAGES]  = '{default: '0};
	logic                slot_busy   [PHYSICAL_SLOTS] = '{default: 1'b0};
	logic [PAGE_W-1:0]   slot_page   [PHYSICAL_SLOTS] = '{default: '0};
	logic [ROUND_W-1:0]  rounds_done = '0;
	cmd_word_t           expected_cmds[$];

	// Mark the page; on the batch's last word walk the pages in ascending order,
	// place each missing one and queue the load words plus the closing done word.
	task automatic predict_request(input logic [PAGE_W-1:0] page, input logic is_last);
		cmd_word_t w;
		int        slot;
		int        loads;
		logic      no_room;
		loads   = 0;
		no_room = 1'b0;
		page_wanted[page] = 1'b1;
		if (!is_last)
			return;
		for (int p = 0; p < VIRTUAL_PAGES && !no_room; p++) begin
			if (page_wanted[p] && page_slot[p] == '0) begin
				// lowest free slot first; scanning downward leaves the lowest hit
				slot = -1;
				for (int s = PHYSICAL_SLOTS - 1; s >= 0; s--)
					if (!slot_busy[s])
						slot = s;
				// all full: lowest slot whose page is not wanted this round
				if (slot < 0)
					for (int s = PHYSICAL_SLOTS - 1; s >= 0; s--)
						if (!page_wanted[slot_page[s]])
							slot = s;
				if (slot < 0) begin
					// every slot pinned by this batch: pass ends here
					no_room = 1'b1;
				end else begin
					w = '0;
					w.kind      = KIND_LOAD;
					w.load_page = PAGE_W'(p);
					w.load_slot = SLOT_W'(slot);
					if (slot_busy[slot]) begin
						w.evict_valid = 1'b1;
						w.evict_page  = slot_page[slot];
						page_slot[slot_page[slot]] = '0;
					end
					slot_busy[slot] = 1'b1;
					slot_page[slot] = PAGE_W'(p);
					page_slot[p]    = (SLOT_W + 1)'(slot + 1);
					loads++;
					expected_cmds.push_back(w);
				end
			end
		end
		rounds_done = rounds_done + 1'b1;
		w = '0;
		w.kind         = KIND_DONE;
		w.round_loads  = LOADS_W'(loads);
		w.total_rounds = rounds_done;
		w.last_of_run  = 1'b1;
		expected_cmds.push_back(w);
		page_wanted = '{default: 1'b0};
	endtask

	function automatic string word_text(input cmd_word_t w);
		return $sformatf("kind=%0d page=%0d slot=%0d ev=%0d ev_page=%0d loads=%0d rounds=%0d last=%0d",
			w.kind, w.load_page, w.load_slot, w.evict_valid, w.evict_page,
			w.round_loads, w.total_rounds, w.last_of_run);
	endfunction

	// ------------------------------------------------------------------
	// Request driver: pops from the pending queue in bursts with random gaps.
	// Payload only moves after an acceptance or while valid is low.
	// ------------------------------------------------------------------
	page_req_t request_queue[$];
	page_req_t next_req;
	int        requests_total;
	int        requests_sent = 0;
	int        burst_left = 1;
	int        gap_left = 0;

	function automatic void queue_request(input int page, input logic is_last);
		page_req_t r;
		r.page    = PAGE_W'(page);
		r.is_last = is_last;
		request_queue.push_back(r);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predict_request(requested_page, batch_last);
				requests_sent++;
			end
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					next_req = request_queue.pop_front();
					req_valid      <= 1'b1;
					requested_page <= next_req.page;
					batch_last     <= next_req.is_last;
					if (burst_left > 1) begin
						burst_left--;
					end else if ($urandom_range(0, 9) == 0) begin
						// long stretch with no gaps at all
						burst_left = $urandom_range(20, 40);
						gap_left   = 0;
					end else begin
						burst_left = $urandom_range(1, 8);
						gap_left   = $urandom_range(1, 6);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side stall generator: its own modes, independent of the sender.
	// ------------------------------------------------------------------
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left = 0;
	int          hold_left = 0;

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left  = $urandom_range(40, 160);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			STALL_NONE: begin
				cmd_stall <= 1'b0;
			end
			STALL_RANDOM: begin
				cmd_stall <= 1'($urandom_range(0, 1));
			end
			STALL_ALTERNATE: begin
				cmd_stall <= !cmd_stall;
			end
			default: begin
				if (hold_left > 0) begin
					hold_left--;
					cmd_stall <= 1'b1;
				end else if ($urandom_range(0, 3) == 0) begin
					hold_left = $urandom_range(1, 12);
					cmd_stall <= 1'b1;
				end else begin
					cmd_stall <= 1'b0;
				end
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Result monitor: every accepted word against the oldest expectation.
	// ------------------------------------------------------------------
	int        bad_words = 0;
	cmd_word_t got_word;
	cmd_word_t exp_word;

	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall) begin
			got_word = '{item_kind, load_page, load_slot, evict_valid, evict_page,
				round_loads, total_rounds, last_of_run};
			if (expected_cmds.size() == 0) begin
				bad_words++;
				if (bad_words <= REPORT_MAX)
					$display("ERROR: unexpected word %s", word_text(got_word));
			end else begin
				exp_word = expected_cmds.pop_front();
				if (got_word.kind !== exp_word.kind
						|| got_word.load_page !== exp_word.load_page
						|| got_word.load_slot !== exp_word.load_slot
						|| got_word.evict_valid !== exp_word.evict_valid
						|| got_word.evict_page !== exp_word.evict_page
						|| got_word.round_loads !== exp_word.round_loads
						|| got_word.total_rounds !== exp_word.total_rounds
						|| got_word.last_of_run !== exp_word.last_of_run) begin
					bad_words++;
					if (bad_words <= REPORT_MAX) begin
						$display("ERROR: word mismatch");
						$display("  expected %s", word_text(exp_word));
						$display("  actual   %s", word_text(got_word));
					end
				end
			end
		end
	end

	// Watchdog: cycles in which neither channel moves a word.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (cmd_valid && !cmd_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("virtual_page_residency_manager test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------
	initial begin
		int batch_len;
		int hot_base;

		// Directed: lone last word, both page extremes into the first slots.
		queue_request(0, 1'b1);
		queue_request(63, 1'b0);
		queue_request(0, 1'b1);
		// Both already resident: done word with zero loads.
		queue_request(0, 1'b0);
		queue_request(63, 1'b1);
		// Ten pages with a repeat: fills the free slots, evicts pages 0 and 63,
		// then hits a table full of wanted pages and stops with eight loads.
		for (int k = 1; k <= 10; k++)
			queue_request(k, 1'b0);
		queue_request(3, 1'b1);
		// Mixed hit and miss right after a full round.
		queue_request(63, 1'b0);
		queue_request(9, 1'b0);
		queue_request(2, 1'b1);

		// Random batches around a drifting hot window so pages come back resident,
		// with some long batches that overflow the slots.
		hot_base = $urandom_range(0, VIRTUAL_PAGES - 12);
		while (request_queue.size() < REQUEST_TARGET) begin
			if ($urandom_range(0, 3) == 0)
				hot_base = $urandom_range(0, VIRTUAL_PAGES - 12);
			batch_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
				: $urandom_range(1, 8);
			for (int k = 0; k < batch_len; k++)
				queue_request(($urandom_range(0, 2) != 0)
					? hot_base + $urandom_range(0, 11)
					: $urandom_range(0, VIRTUAL_PAGES - 1), k == batch_len - 1);
		end
		requests_total = request_queue.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (requests_sent < requests_total)
			@(posedge clk);
		while (expected_cmds.size() != 0)
			@(posedge clk);
		// any stray word after the last done would show up here
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bad_words == 0 && expected_cmds.size() == 0)
			$display("virtual_page_residency_manager test passed");
		else
			$display("virtual_page_residency_manager test failed");
		$finish;
	end

endmodule

// ----- virtual_page_residency_manager.f -----
design/vprm_pkg.sv
design/vprm_ctrl.sv
design/vprm_dpath.sv
design/virtual_page_residency_manager.sv
dv/tb_top.sv
